// ===== rtl/hrdm_pkg.sv =====
// Shared types and constants for the HID report descriptor mouse layout finder.
// No dependencies; imported by every module of the block.
package hrdm_pkg;

  localparam logic [7:0] TAG_USAGE_PAGE     = 8'h04;
  localparam logic [7:0] TAG_USAGE          = 8'h08;
  localparam logic [7:0] TAG_COLLECTION     = 8'hA0;
  localparam logic [7:0] TAG_END_COLLECTION = 8'hC0;
  localparam logic [7:0] TAG_REPORT_COUNT   = 8'h94;
  localparam logic [7:0] TAG_REPORT_SIZE    = 8'h74;
  localparam logic [7:0] TAG_INPUT          = 8'h80;
  localparam logic [7:0] TAG_REPORT_ID      = 8'h84;
  localparam logic [7:0] TAG_MASK           = 8'hFC;

  localparam logic [31:0] PAGE_BUTTONS = 32'h09;
  localparam logic [31:0] USE_POINTER  = 32'h01;
  localparam logic [31:0] USE_MOUSE    = 32'h02;
  localparam logic [31:0] USE_X        = 32'h30;
  localparam logic [31:0] USE_Y        = 32'h31;
  localparam logic [31:0] USE_WHEEL    = 32'h38;

  localparam logic [1:0] SLOT_BUTTONS = 2'd0;
  localparam logic [1:0] SLOT_X       = 2'd1;
  localparam logic [1:0] SLOT_Y       = 2'd2;
  localparam logic [1:0] SLOT_WHEEL   = 2'd3;

  localparam int unsigned NUM_FIELDS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  // one parsed item handed from the byte assembler to the executor
  typedef struct packed {
    logic        is_item;
    logic        last;
    logic [7:0]  prefix;
    logic [31:0] arg;
  } item_t;

  typedef struct packed {
    logic [7:0]                  report_id;
    logic [13:0]                 report_bytes;
    logic [NUM_FIELDS-1:0][15:0] offset;
    logic [NUM_FIELDS-1:0][15:0] size;
  } result_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_WALK,
    ST_ADD,
    ST_FINISH
  } back_state_e;

  function automatic logic [2:0] data_len(input logic [7:0] prefix);
    logic [2:0] n;
    begin
      n = (prefix[1:0] == 2'b11) ? 3'd4 : {1'b0, prefix[1:0]};
      return n;
    end
  endfunction

endpackage

// ===== rtl/hid_report_descriptor_mouse_layout_top.sv =====
// Top level of the HID report descriptor mouse layout finder.
// Depends on hrdm_pkg, hrdm_front, hrdm_queue and hrdm_back.
//
//  channel | dir | handshake                     | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] desc_byte, tlast last_byte
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata[151:0] layout result
//
// Bytes are taken one per cycle while the two-entry item queue has room.
// The executor handles one queued item at a time; an Input item while parsing
// goes through the multiply, a walk over each queued usage on a data Input, and
// the position add; the last byte then loads the result register.
// Reset is asynchronous, active low, and leaves the block ready at once.
// The result register holds the layout until taken; the executor waits on it.
module hid_report_descriptor_mouse_layout_top
  import hrdm_pkg::*;
#(
  parameter int unsigned USAGE_SLOTS = 4,
  parameter int unsigned POS_WIDTH   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] desc_byte
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata   // report_id, report_bytes, buttons_offset,
                                      // buttons_size, x_offset, x_size, y_offset,
                                      // y_size, wheel_offset, wheel_size, zero pad
);

  logic    q_full;
  logic    push;
  item_t   entry;
  item_t   head;
  logic    head_valid;
  logic    pop;
  result_t res;

  hrdm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .byte_ready_o (s_axis_tready),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (entry)
  );

  hrdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .full_o  (q_full)
  );

  hrdm_back #(
    .USAGE_SLOTS (USAGE_SLOTS),
    .POS_WIDTH   (POS_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {2'b00,
                         res.size[SLOT_WHEEL],   res.offset[SLOT_WHEEL],
                         res.size[SLOT_Y],       res.offset[SLOT_Y],
                         res.size[SLOT_X],       res.offset[SLOT_X],
                         res.size[SLOT_BUTTONS], res.offset[SLOT_BUTTONS],
                         res.report_bytes, res.report_id};

endmodule

// ===== rtl/hrdm_front.sv =====
// Byte assembler: groups descriptor bytes into short items and sign-extends data.
// Depends on hrdm_pkg; feeds hrdm_queue.
module hrdm_front
  import hrdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       byte_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output item_t      entry_o
);

  logic [7:0]  prefix_q, prefix_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] accum_q, accum_d;
  logic        take;
  logic        complete;
  logic [2:0]  n;
  logic [1:0]  idx;
  logic [2:0]  idx_full;
  logic [31:0] arg;

  assign byte_ready_o = !q_full_i;
  assign take = byte_valid_i && byte_ready_o;

  always_comb begin
    prefix_d = prefix_q;
    left_d   = left_q;
    accum_d  = accum_q;
    complete = 1'b0;
    arg      = 32'd0;
    n        = data_len(prefix_q);
    idx_full = n - left_q;
    idx      = idx_full[1:0];
    entry_o.prefix = prefix_q;
    if (take) begin
      if (left_q == 3'd0) begin
        prefix_d = byte_i;
        accum_d  = 32'd0;
        left_d   = data_len(byte_i);
        complete = (data_len(byte_i) == 3'd0);
        entry_o.prefix = byte_i;
      end else begin
        accum_d  = accum_q | (32'(byte_i) << {idx, 3'b000});
        left_d   = left_q - 3'd1;
        complete = (left_d == 3'd0);
        arg      = accum_d;
        if (n == 3'd1 && accum_d[7]) begin
          arg = accum_d | 32'hFFFF_FF00;
        end else if (n == 3'd2 && accum_d[15]) begin
          arg = accum_d | 32'hFFFF_0000;
        end
      end
      if (last_i) begin
        left_d = 3'd0;
      end
    end
    entry_o.is_item = complete;
    entry_o.last    = last_i;
    entry_o.arg     = arg;
    push_o = take && (complete || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
    accum_q  <= accum_d;
  end

endmodule

// ===== rtl/hrdm_queue.sv =====
// Short item queue between the byte assembler and the executor.
// Depends on hrdm_pkg for the item type.
module hrdm_queue
  import hrdm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t entry_i,
  input  logic  pop_i,
  output item_t head_o,
  output logic  valid_o,
  output logic  full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign valid_o = (cnt_q != CW'(0));
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full item queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("pop from empty item queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("item queue count out of range");
`endif

endmodule

// ===== rtl/hrdm_back.sv =====
// Item executor: collection/usage tracking, layout assignment, result register.
// Depends on hrdm_pkg; fed by hrdm_queue.
module hrdm_back
  import hrdm_pkg::*;
#(
  parameter int unsigned USAGE_SLOTS = 4,
  parameter int unsigned POS_WIDTH   = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   head_i,
  input  logic    head_valid_i,
  output logic    pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int unsigned IW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(USAGE_SLOTS + 1);

  back_state_e           state_q, state_d;
  logic [7:0]            depth_q, depth_d;
  logic                  parse_q, parse_d;
  logic                  mouse_q, mouse_d;
  logic [7:0]            id_q, id_d;
  logic [POS_WIDTH-1:0]  bp_q, bp_d;
  logic [POS_WIDTH-1:0]  fs_q, fs_d;
  logic [POS_WIDTH-1:0]  fc_q, fc_d;
  logic [1:0]            pend_q [USAGE_SLOTS];
  logic [1:0]            pend_d [USAGE_SLOTS];
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [POS_WIDTH-1:0]  off_q [NUM_FIELDS];
  logic [POS_WIDTH-1:0]  off_d [NUM_FIELDS];
  logic [POS_WIDTH-1:0]  siz_q [NUM_FIELDS];
  logic [POS_WIDTH-1:0]  siz_d [NUM_FIELDS];
  logic [POS_WIDTH-1:0]  prod_q, prod_d;
  logic [POS_WIDTH-1:0]  pos_q, pos_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  rv_q, rv_d;
  result_t               res_q, res_d;

  logic [7:0]            tag;
  logic [31:0]           arg;
  logic                  input_run;
  logic                  is_data;
  logic                  out_free;
  logic [1:0]            slot;
  logic [POS_WIDTH-1:0]  sz;
  logic [47:0]           bp_ext;
  logic                  queue_en;
  logic [1:0]            queue_slot;

  assign tag       = head_i.prefix & TAG_MASK;
  assign arg       = head_i.arg;
  assign is_data   = (arg[1:0] == 2'b10);
  assign input_run = head_i.is_item && (tag == TAG_INPUT) && parse_q;
  assign out_free  = !rv_q || res_ready_i;
  assign slot      = pend_q[idx_q];
  assign sz        = (slot == SLOT_BUTTONS) ? fc_q : fs_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EXEC: begin
        if (head_valid_i) begin
          if (input_run) begin
            state_d = (is_data && cnt_q != CW'(0)) ? ST_WALK : ST_ADD;
          end else if (head_i.last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (CW'(idx_q) == cnt_q - CW'(1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = head_i.last ? ST_FINISH : ST_EXEC;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_EXEC;
        end
      end
      default: state_d = ST_EXEC;
    endcase
  end

  // datapath and outputs
  always_comb begin
    depth_d    = depth_q;
    parse_d    = parse_q;
    mouse_d    = mouse_q;
    id_d       = id_q;
    bp_d       = bp_q;
    fs_d       = fs_q;
    fc_d       = fc_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    off_d      = off_q;
    siz_d      = siz_q;
    prod_d     = prod_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    rv_d       = rv_q && !res_ready_i;
    res_d      = res_q;
    pop_o      = 1'b0;
    queue_en   = 1'b0;
    queue_slot = SLOT_BUTTONS;
    bp_ext     = 48'(bp_q) + 48'd7;

    unique case (state_q)
      ST_EXEC: begin
        if (head_valid_i) begin
          if (input_run) begin
            prod_d = fc_q * fs_q;
            pos_d  = bp_q;
            idx_d  = '0;
          end else begin
            pop_o = 1'b1;
            if (head_i.is_item) begin
              if (tag == TAG_COLLECTION) begin
                depth_d = depth_q + 8'd1;
              end else if (tag == TAG_END_COLLECTION) begin
                depth_d = depth_q - 8'd1;
                if (depth_d == 8'd0) begin
                  parse_d = 1'b0;
                end
              end else if (tag == TAG_USAGE) begin
                if (arg == USE_MOUSE) begin
                  mouse_d = 1'b1;
                end else if (arg == USE_POINTER && id_q == 8'd0) begin
                  parse_d = 1'b1;
                end
              end else if (tag == TAG_REPORT_ID && mouse_q) begin
                if (id_q == 8'd0) begin
                  id_d    = arg[7:0];
                  bp_d    = bp_q + POS_WIDTH'(8);
                  parse_d = 1'b1;
                end else begin
                  parse_d = (arg[7:0] == id_q);
                end
              end
              if (parse_d) begin
                if (tag == TAG_USAGE_PAGE) begin
                  if (arg == PAGE_BUTTONS) begin
                    queue_en   = 1'b1;
                    queue_slot = SLOT_BUTTONS;
                  end
                end else if (tag == TAG_USAGE) begin
                  if (arg == USE_X) begin
                    queue_en   = 1'b1;
                    queue_slot = SLOT_X;
                  end else if (arg == USE_Y) begin
                    queue_en   = 1'b1;
                    queue_slot = SLOT_Y;
                  end else if (arg == USE_WHEEL) begin
                    queue_en   = 1'b1;
                    queue_slot = SLOT_WHEEL;
                  end
                end else if (tag == TAG_REPORT_SIZE) begin
                  fs_d = arg[POS_WIDTH-1:0];
                end else if (tag == TAG_REPORT_COUNT) begin
                  fc_d = arg[POS_WIDTH-1:0];
                end
              end
              if (queue_en && cnt_q < CW'(USAGE_SLOTS)) begin
                pend_d[cnt_q[IW-1:0]] = queue_slot;
                cnt_d = cnt_q + CW'(1);
              end
            end
          end
        end
      end
      ST_WALK: begin
        off_d[slot] = pos_q;
        siz_d[slot] = sz;
        pos_d = pos_q + sz;
        idx_d = idx_q + IW'(1);
      end
      ST_ADD: begin
        pop_o = 1'b1;
        bp_d  = bp_q + prod_q;
        if (is_data) begin
          cnt_d = '0;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          rv_d = 1'b1;
          res_d.report_id    = id_q;
          res_d.report_bytes = bp_ext[16:3];
          for (int k = 0; k < NUM_FIELDS; k++) begin
            res_d.offset[k] = 16'(off_q[k]);
            res_d.size[k]   = 16'(siz_q[k]);
          end
          depth_d = '0;
          parse_d = 1'b0;
          mouse_d = 1'b0;
          id_d    = '0;
          bp_d    = '0;
          fs_d    = '0;
          fc_d    = '0;
          cnt_d   = '0;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            off_d[k] = '0;
            siz_d[k] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXEC;
      depth_q <= '0;
      parse_q <= 1'b0;
      mouse_q <= 1'b0;
      id_q    <= '0;
      bp_q    <= '0;
      fs_q    <= '0;
      fc_q    <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        off_q[k] <= '0;
        siz_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      parse_q <= parse_d;
      mouse_q <= mouse_d;
      id_q    <= id_d;
      bp_q    <= bp_d;
      fs_q    <= fs_d;
      fc_q    <= fc_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      off_q   <= off_d;
      siz_q   <= siz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    prod_q <= prod_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(USAGE_SLOTS))
    else $error("usage queue count out of range");
  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> CW'(idx_q) < cnt_q)
    else $error("layout walk past queued usages");
  a_walk_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_ADD) |-> head_valid_i)
    else $error("Input item lost during layout walk");
  a_add_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && is_data) |=> cnt_q == CW'(0))
    else $error("usage queue not cleared by data Input");
`endif

endmodule
